// ===== hdl/mht_pkg.sv =====
// Package for the MAC hash table: payload structs, status codes, state enum, hash function.
// No dependencies; used by mht_ctrl and mac_hash_table_with_aging.
`timescale 1ns / 1ps
package mht_pkg;
	localparam int ENTRIES_DEF = 64;
	localparam int BUCKETS_DEF = 16;
	localparam logic [1:0] AGE_LIMIT_RST = 2'd2;

	typedef enum logic [1:0] {
		OP_LEARN  = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_AGE    = 2'd2,
		OP_RSVD   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_HIT      = 3'd0,
		ST_INSERTED = 3'd1,
		ST_MISS     = 3'd2,
		ST_FULL     = 3'd3,
		ST_SWEPT    = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [47:0] mac;
	} in_word_t;

	typedef struct packed {
		logic [2:0] status;
		logic [6:0] entry_index;
	} out_word_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_HEAD,
		S_WALK,
		S_CHECK,
		S_FREE,
		S_FREE_WAIT,
		S_INSERT,
		S_LINK,
		S_SW_HEAD,
		S_SW_RD,
		S_SW_CHECK,
		S_DONE
	} fsm_t;

	// Fold the six address bytes, OR in the high nibble
	function automatic logic [7:0] mac_fold(input logic [47:0] mac);
		logic [7:0] x;
		x = mac[7:0] ^ mac[15:8] ^ mac[23:16] ^ mac[31:24] ^ mac[39:32] ^ mac[47:40];
		return x | (x >> 4);
	endfunction
endpackage

// ===== hdl/mht_ctrl.sv =====
// Controller for the MAC hash table: walks chains, inserts, ages; owns entry and head memories.
// Depends on mht_pkg.
`timescale 1ns / 1ps
module mht_ctrl #(
	parameter int ENTRIES = mht_pkg::ENTRIES_DEF,
	parameter int BUCKETS = mht_pkg::BUCKETS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         age_limit,
	input  logic               start,
	input  mht_pkg::in_word_t  req,
	output logic               busy,
	output logic               done,
	output mht_pkg::out_word_t rsp
);
	import mht_pkg::*;

	localparam int EW = $clog2(ENTRIES);
	localparam int LW = $clog2(ENTRIES + 1);
	localparam int BW = $clog2(BUCKETS);

	// Link memory word: age and next link of one entry
	typedef struct packed {
		logic [1:0]    age;
		logic [LW-1:0] next;
	} lnk_t;

	// Address and link memories (one read port each, registered output)
	logic [47:0] addr_mem [ENTRIES];
	lnk_t        lnk_mem  [ENTRIES];
	logic [47:0] addr_rd;
	lnk_t        lnk_rd;
	// Valid bits and bucket heads have reset values: flops
	logic [ENTRIES-1:0] valid_q;
	logic [LW-1:0]      head_q [BUCKETS];

	fsm_t          state_q, state_d;
	logic [47:0]   mac_q;
	logic          learn_q;
	logic [BW-1:0] bkt_q;
	logic [LW-1:0] cur_q, prev_q;
	logic [1:0]    prev_age_q;
	logic [EW:0]   steps_q;
	logic [EW:0]   scan_q;
	logic [LW-1:0] free_q;
	logic          found_q;
	out_word_t     rsp_q;

	logic [EW-1:0] cur_e, prev_e;
	logic          link_ok;
	logic          age_out;
	logic [1:0]    age_inc;
	assign cur_e   = EW'(cur_q - LW'(1));
	assign prev_e  = EW'(prev_q - LW'(1));
	assign link_ok = (cur_q != '0) && (cur_q <= LW'(ENTRIES)) && (steps_q < (EW+1)'(ENTRIES));
	assign age_out = (lnk_rd.age >= age_limit);
	assign age_inc = (lnk_rd.age == 2'd3) ? 2'd3 : lnk_rd.age + 2'd1;

	// Reduce the folded hash to a bucket through a constant table
	function automatic logic [BW-1:0] bkt_of(input logic [7:0] x);
		logic [BW-1:0] r;
		r = '0;
		for (int i = 0; i < 256; i++)
			if (x == 8'(i)) r = BW'(i % BUCKETS);
		return r;
	endfunction

	// Memory read address and write controls
	logic          lnk_we;
	logic [EW-1:0] mem_wa;
	lnk_t          lnk_wd;
	logic          addr_we;

	always_ff @(posedge clk) begin
		if (addr_we) addr_mem[mem_wa] <= mac_q;
		if (lnk_we)  lnk_mem[mem_wa]  <= lnk_wd;
		addr_rd <= addr_mem[cur_e];
		lnk_rd  <= lnk_mem[cur_e];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:      if (start) state_d = (op_t'(req.op) == OP_AGE) ? S_SW_HEAD : S_HEAD;
			S_HEAD:      state_d = S_WALK;
			S_WALK:      state_d = link_ok ? S_CHECK : (learn_q ? S_FREE : S_DONE);
			S_CHECK:     state_d = (addr_rd == mac_q) ? S_DONE : S_WALK;
			S_FREE:      state_d = found_q ? S_INSERT :
				(scan_q == (EW+1)'(ENTRIES - 1) ? S_FREE_WAIT : S_FREE);
			S_FREE_WAIT: state_d = found_q ? S_INSERT : S_DONE;
			S_INSERT:    state_d = S_LINK;
			S_LINK:      state_d = S_DONE;
			S_SW_HEAD:   state_d = S_SW_RD;
			S_SW_RD:     state_d = link_ok ? S_SW_CHECK :
				(bkt_q == BW'(BUCKETS - 1) ? S_DONE : S_SW_HEAD);
			S_SW_CHECK:  state_d = S_SW_RD;
			S_DONE:      state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	// Memory writes: one link word per cycle
	always_comb begin
		lnk_we  = 1'b0;
		addr_we = 1'b0;
		mem_wa  = cur_e;
		lnk_wd  = '{age: 2'd0, next: '0};
		case (state_q)
			S_CHECK: begin
				if (addr_rd == mac_q && learn_q) begin
					lnk_we = 1'b1;
					lnk_wd = '{age: 2'd0, next: lnk_rd.next};
				end
			end
			S_INSERT: begin
				lnk_we  = 1'b1;
				addr_we = 1'b1;
				mem_wa  = EW'(free_q - LW'(1));
			end
			S_LINK: begin
				// Append the new entry to the chain tail
				if (prev_q != '0) begin
					lnk_we = 1'b1;
					mem_wa = prev_e;
					lnk_wd = '{age: prev_age_q, next: free_q};
				end
			end
			S_SW_CHECK: begin
				if (age_out) begin
					if (prev_q != '0) begin
						lnk_we = 1'b1;
						mem_wa = prev_e;
						lnk_wd = '{age: prev_age_q, next: lnk_rd.next};
					end
				end else begin
					lnk_we = 1'b1;
					lnk_wd = '{age: age_inc, next: lnk_rd.next};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			for (int i = 0; i < BUCKETS; i++) head_q[i] <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_INSERT: begin
					valid_q[EW'(free_q - LW'(1))] <= 1'b1;
					if (prev_q == '0) head_q[bkt_q] <= free_q;
				end
				S_SW_CHECK: begin
					if (age_out) begin
						valid_q[cur_e] <= 1'b0;
						if (prev_q == '0) head_q[bkt_q] <= lnk_rd.next;
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				mac_q   <= req.mac;
				learn_q <= (op_t'(req.op) == OP_LEARN);
				bkt_q   <= bkt_of(mac_fold(req.mac));
				prev_q  <= '0;
				steps_q <= '0;
				scan_q  <= '0;
				found_q <= 1'b0;
				free_q  <= '0;
				rsp_q   <= '{status: ST_MISS, entry_index: '0};
				if (op_t'(req.op) == OP_AGE) bkt_q <= '1;
			end
			S_HEAD: cur_q <= head_q[bkt_q];
			S_CHECK: begin
				if (addr_rd == mac_q) begin
					rsp_q <= '{status: ST_HIT, entry_index: 7'(cur_q)};
				end else begin
					prev_q     <= cur_q;
					prev_age_q <= lnk_rd.age;
					cur_q      <= lnk_rd.next;
					steps_q    <= steps_q + 1'b1;
				end
			end
			S_WALK: if (!link_ok && learn_q) rsp_q <= '{status: ST_FULL, entry_index: '0};
			S_FREE, S_FREE_WAIT: begin
				// Scan valid bits, one per cycle, for the lowest free entry
				if (!found_q && !valid_q[scan_q[EW-1:0]]) begin
					found_q <= 1'b1;
					free_q  <= LW'(scan_q) + LW'(1);
				end
				if (scan_q != (EW+1)'(ENTRIES - 1)) scan_q <= scan_q + 1'b1;
			end
			S_INSERT: rsp_q <= '{status: ST_INSERTED, entry_index: 7'(free_q)};
			S_SW_HEAD: begin
				bkt_q   <= bkt_q + 1'b1;
				cur_q   <= head_q[BW'(bkt_q + 1'b1)];
				prev_q  <= '0;
				steps_q <= '0;
				rsp_q   <= '{status: ST_SWEPT, entry_index: '0};
			end
			S_SW_CHECK: begin
				if (!age_out) begin
					prev_q     <= cur_q;
					prev_age_q <= age_inc;
				end
				cur_q   <= lnk_rd.next;
				steps_q <= steps_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	assign rsp  = rsp_q;
endmodule

// ===== hdl/mac_hash_table_with_aging.sv =====
// Top level of the MAC hash table with aging: handshakes, config register, output register.
// Depends on mht_pkg and mht_ctrl.
//
//  channel   direction  handshake       payload
//  in        input      in_valid/stall  in_word_t {op, mac}
//  out       output     out_valid/stall out_word_t {status, entry_index}
//  cfg       input      cfg_we          cfg_data (age_limit)
//
// One word at a time. Lookup/learn walks the bucket chain, reading each link from the
// link/address memories; a learn miss adds a valid-bit scan of up to ENTRIES entries
// and the insert and link writes. Aging tick walks the chain of every bucket.
// Reset clears valid bits, bucket heads and sets age_limit to 2.
// A result held by out_stall blocks the next word until it is taken.
`timescale 1ns / 1ps
module mac_hash_table_with_aging #(
	parameter int ENTRIES = mht_pkg::ENTRIES_DEF,
	parameter int BUCKETS = mht_pkg::BUCKETS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  mht_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output mht_pkg::out_word_t out_word
);
	import mht_pkg::*;

	logic [1:0] age_lim_q;
	logic      busy, done, start;
	out_word_t rsp;
	logic      out_valid_q;
	out_word_t out_q;

	// Hold the age limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) age_lim_q <= AGE_LIMIT_RST;
		else if (cfg_we) age_lim_q <= cfg_data;
	end

	// Accept when controller idle and no result waiting
	assign in_stall = busy || out_valid_q;
	assign start    = in_valid && !in_stall;

	mht_ctrl #(.ENTRIES(ENTRIES), .BUCKETS(BUCKETS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .age_limit(age_lim_q), .start(start),
		.req(in_word), .busy(busy), .done(done), .rsp(rsp)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (done) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (done) out_q <= rsp;
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !start) else $error("word accepted while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done without work");
	a_out_set: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> out_valid) else $error("result lost");
`endif
endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for mac_hash_table_with_aging: drives learn, lookup and aging words,
// predicts each result with a behavioral table model. Depends on mht_pkg and the block RTL.
`timescale 1ns / 1ps
module testbench;
	import mht_pkg::*;

	localparam int NENT = ENTRIES_DEF;
	localparam int NBKT = BUCKETS_DEF;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_data = 2'd0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_word_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_word_t out_word;

	mac_hash_table_with_aging u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
	);

	always #1 clk = ~clk;

	// Table shadow
	bit          tbl_valid [NENT];
	logic [1:0]  tbl_age [NENT];
	logic [6:0]  tbl_next [NENT];
	logic [47:0] tbl_addr [NENT];
	logic [6:0]  tbl_head [NBKT];
	logic [1:0]  age_limit_q = AGE_LIMIT_RST;

	in_word_t  pending_words [$];
	out_word_t expected_results [$];
	int mismatch_count = 0;
	int idle_cycles = 0;

	// Learned addresses, for hits
	logic [47:0] known_macs [$];

	function automatic int bucket_index(logic [47:0] mac);
		logic [7:0] x;
		x = 8'd0;
		for (int i = 0; i < 6; i++) x ^= mac[8*i +: 8];
		return int'((x | (x >> 4)) % NBKT);
	endfunction

	function automatic out_word_t predict_table(in_word_t w);
		out_word_t r;
		int b, cur, tail, prev, nxt, steps;
		bit hit;
		r = '0;
		if (w.op == OP_AGE) begin
			for (b = 0; b < NBKT; b++) begin
				prev = 0;
				cur = tbl_head[b];
				steps = 0;
				while (cur != 0 && cur <= NENT && steps < NENT) begin
					nxt = tbl_next[cur-1];
					if (tbl_age[cur-1] >= age_limit_q) begin
						tbl_valid[cur-1] = 1'b0;
						tbl_age[cur-1] = 2'd0;
						if (prev != 0) tbl_next[prev-1] = nxt[6:0];
						else tbl_head[b] = nxt[6:0];
					end else begin
						if (tbl_age[cur-1] < 2'd3) tbl_age[cur-1]++;
						prev = cur;
					end
					cur = nxt;
					steps++;
				end
			end
			r.status = ST_SWEPT;
			return r;
		end
		b = bucket_index(w.mac);
		cur = tbl_head[b];
		tail = 0;
		steps = 0;
		hit = 1'b0;
		while (cur != 0 && cur <= NENT && steps < NENT) begin
			if (tbl_addr[cur-1] == w.mac) begin
				hit = 1'b1;
				break;
			end
			tail = cur;
			cur = tbl_next[cur-1];
			steps++;
		end
		if (hit) begin
			if (w.op == OP_LEARN) tbl_age[cur-1] = 2'd0;
			r.status = ST_HIT;
			r.entry_index = cur[6:0];
		end else if (w.op != OP_LEARN) begin
			r.status = ST_MISS;
		end else begin
			cur = 0;
			for (int i = 0; i < NENT; i++)
				if (!tbl_valid[i]) begin
					cur = i + 1;
					break;
				end
			if (cur == 0) begin
				r.status = ST_FULL;
			end else begin
				tbl_valid[cur-1] = 1'b1;
				tbl_age[cur-1] = 2'd0;
				tbl_next[cur-1] = 7'd0;
				tbl_addr[cur-1] = w.mac;
				if (tail != 0) tbl_next[tail-1] = cur[6:0];
				else tbl_head[b] = cur[6:0];
				r.status = ST_INSERTED;
				r.entry_index = cur[6:0];
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 40) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// Driver: present queued words, predict on accept
	int in_gap = 0;
	always @(posedge clk) begin
		if (in_valid && !in_stall) expected_results.push_back(predict_table(in_word));
		if (in_valid && in_stall) begin
			// hold stalled word
		end else if (in_gap > 0) begin
			in_gap <= in_gap - 1;
			in_valid <= 1'b0;
		end else if (pending_words.size() > 0 && arst_n) begin
			in_word <= pending_words.pop_front();
			in_valid <= 1'b1;
			in_gap <= gap_len();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Monitor: compare accepted results, randomize stall
	int out_gap = 0;
	always @(posedge clk) begin
		out_word_t exp_w;
		if (out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result %p", out_word));
			end else begin
				exp_w = expected_results.pop_front();
				if (out_word.status !== exp_w.status)
					report_mismatch($sformatf("status got %0d exp %0d",
						out_word.status, exp_w.status));
				if (out_word.entry_index !== exp_w.entry_index)
					report_mismatch($sformatf("entry_index got %0d exp %0d",
						out_word.entry_index, exp_w.entry_index));
			end
		end
		if (out_gap > 0) begin
			out_gap <= out_gap - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			out_gap <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
		end
	end

	// Watchdog: count cycles with no accepted word
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("mac_hash_table_with_aging regression: fail");
			$finish;
		end
	end

	function automatic logic [47:0] rand_mac();
		return {$urandom(), 16'($urandom())};
	endfunction

	function automatic in_word_t make_word(op_t op, logic [47:0] mac);
		in_word_t w;
		w.op = op;
		w.mac = mac;
		return w;
	endfunction

	// Push a word, remembering learned addresses
	task automatic queue_word(op_t op, logic [47:0] mac);
		pending_words.push_back(make_word(op, mac));
		if (op == OP_LEARN && known_macs.size() < 200) known_macs.push_back(mac);
	endtask

	task automatic drain_and_wait();
		wait (pending_words.size() == 0 && !in_valid);
		wait (expected_results.size() == 0);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_age_limit(logic [1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		age_limit_q = v;
	endtask

	// Random phase: mostly learn/lookup, often of known addresses, with sweeps
	task automatic random_phase(int n);
		int p;
		logic [47:0] m;
		for (int i = 0; i < n; i++) begin
			p = $urandom_range(0, 99);
			if (known_macs.size() > 0 && $urandom_range(0, 1))
				m = known_macs[$urandom_range(0, known_macs.size() - 1)];
			else if ($urandom_range(0, 3) == 0)
				m = {44'h0, 4'($urandom())} ^ {40'h0, 8'($urandom())};
			else
				m = rand_mac();
			if (p < 50) queue_word(OP_LEARN, m);
			else if (p < 85) queue_word(OP_LOOKUP, m);
			else if (p < 95) queue_word(OP_AGE, m);
			else queue_word(OP_RSVD, m);
		end
	endtask

	initial begin
		for (int i = 0; i < NENT; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_age[i] = 2'd0;
			tbl_next[i] = 7'd0;
			tbl_addr[i] = '0;
		end
		for (int i = 0; i < NBKT; i++) tbl_head[i] = 7'd0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		// Directed: extremes, every op, collisions, unused op code
		queue_word(OP_LOOKUP, 48'h0);
		queue_word(OP_LEARN, 48'h0);
		queue_word(OP_LEARN, 48'hFFFF_FFFF_FFFF);
		queue_word(OP_LEARN, 48'h0);
		queue_word(OP_LOOKUP, 48'hFFFF_FFFF_FFFF);
		queue_word(OP_LEARN, 48'h0101_0000_0000);
		queue_word(OP_LEARN, 48'h0000_0000_0101);
		queue_word(OP_LOOKUP, 48'h0000_0000_0101);
		queue_word(OP_RSVD, 48'h0);
		queue_word(OP_RSVD, 48'h1234_5678_9ABC);
		queue_word(OP_AGE, 48'hFFFF_FFFF_FFFF);
		queue_word(OP_LEARN, 48'h0);
		queue_word(OP_AGE, 48'h0);
		queue_word(OP_AGE, 48'h0);
		queue_word(OP_LOOKUP, 48'h0);
		queue_word(OP_LOOKUP, 48'hFFFF_FFFF_FFFF);
		drain_and_wait();
		// Fill the table to see full
		for (int i = 0; i < NENT + 3; i++) queue_word(OP_LEARN, rand_mac());
		queue_word(OP_LEARN, rand_mac());
		drain_and_wait();
		write_age_limit(2'd3);
		random_phase(300);
		drain_and_wait();
		write_age_limit(2'd0);
		queue_word(OP_AGE, 48'h0);
		random_phase(300);
		drain_and_wait();
		write_age_limit(2'd1);
		random_phase(500);
		drain_and_wait();
		write_age_limit(2'd2);
		random_phase(600);
		drain_and_wait();
		if (mismatch_count == 0)
			$display("mac_hash_table_with_aging regression: pass");
		else
			$display("mac_hash_table_with_aging regression: fail");
		$finish;
	end
endmodule
